[rtl/m3mu_pkg.sv]
// Package for the 3x3 fixed-point multiply unit: op codes, sequencer states, store indexing.
package m3mu_pkg;

  localparam logic [2:0] OP_LOAD_LEFT  = 3'd0;
  localparam logic [2:0] OP_LOAD_RIGHT = 3'd1;
  localparam logic [2:0] OP_MAT_MAT    = 3'd2;
  localparam logic [2:0] OP_MAT_VEC    = 3'd3;
  localparam logic [2:0] OP_VEC_MAT    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  // row-major position of element (r, c) in a 3x3 store
  function automatic logic [3:0] elem_idx(input logic [1:0] r, input logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

endpackage

[rtl/matrix3_multiply_unit.sv]
// 3x3 signed fixed-point multiply unit: element stores, shared multiply-accumulate sequencer.
//
// A load beat (op 0 or 1) writes one element in the cycle it is accepted and leaves busy low,
// so loads go at one per cycle while busy is low; loads with row or col of 3 and ops 5 to 7 are
// dropped. A compute beat raises busy and runs every result through one shared multiplier and
// one accumulator: three multiply/accumulate pairs plus a shift-and-saturate step. A
// matrix-matrix product gives nine results, matrix-vector and vector-matrix three. Each result
// is on out_* for exactly one cycle with out_valid high, in the cycle after its final step; the
// receiver cannot stall, so results must be taken as they come. out_last marks the final result.
module matrix3_multiply_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [1:0]         in_row,
  input  logic [1:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic               out_saturated,
  output logic               out_last
);

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int TOP_W  = ACC_W - DATA_WIDTH + 1;
  localparam logic signed [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  m3mu_pkg::state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [4:0] frac_r;

  logic signed [DATA_WIDTH-1:0] left_r  [0:8];
  logic signed [DATA_WIDTH-1:0] right_r [0:8];
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r;

  logic                         out_valid_r;
  logic signed [31:0]           out_value_r;
  logic [1:0]                   out_row_r, out_col_r;
  logic                         out_sat_r, out_last_r;

  logic                         accept, is_load, pos_ok, elem_done;
  logic signed [DATA_WIDTH-1:0] a_op, b_op, res_v;
  logic signed [ACC_W-1:0]      shifted;
  logic [TOP_W-1:0]             top_bits;
  logic                         fits;

  assign accept  = start && (state_r == m3mu_pkg::ST_IDLE);
  assign is_load = (in_op == m3mu_pkg::OP_LOAD_LEFT) || (in_op == m3mu_pkg::OP_LOAD_RIGHT);
  assign pos_ok  = (in_row != 2'd3) && (in_col != 2'd3);

  assign a_op = left_r[m3mu_pkg::elem_idx(i_r, k_r)];
  assign b_op = right_r[m3mu_pkg::elem_idx(k_r, j_r)];

  assign shifted  = acc_r >>> frac_r;
  assign top_bits = shifted[ACC_W-1:DATA_WIDTH-1];
  assign fits     = (&top_bits) || ~(|top_bits);
  assign res_v    = fits ? shifted[DATA_WIDTH-1:0] : (acc_r[ACC_W-1] ? MIN_V : MAX_V);

  always_comb begin
    unique case (op_r)
      m3mu_pkg::OP_MAT_VEC: elem_done = (i_r == 2'd2);
      m3mu_pkg::OP_VEC_MAT: elem_done = (j_r == 2'd2);
      default:              elem_done = (i_r == 2'd2) && (j_r == 2'd2);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      m3mu_pkg::ST_IDLE: begin
        if (accept && (in_op == m3mu_pkg::OP_MAT_MAT || in_op == m3mu_pkg::OP_MAT_VEC ||
                       in_op == m3mu_pkg::OP_VEC_MAT)) begin
          state_nxt = m3mu_pkg::ST_MUL;
          op_nxt    = in_op;
          i_nxt     = 2'd0;
          j_nxt     = 2'd0;
          k_nxt     = 2'd0;
        end
      end
      m3mu_pkg::ST_MUL: state_nxt = m3mu_pkg::ST_ACC;
      m3mu_pkg::ST_ACC: begin
        if (k_r == 2'd2) begin
          state_nxt = m3mu_pkg::ST_FIN;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = m3mu_pkg::ST_MUL;
        end
      end
      m3mu_pkg::ST_FIN: begin
        k_nxt = 2'd0;
        if (elem_done) begin
          state_nxt = m3mu_pkg::ST_IDLE;
        end else begin
          state_nxt = m3mu_pkg::ST_MUL;
          priority if (op_r == m3mu_pkg::OP_MAT_VEC) begin
            i_nxt = i_r + 2'd1;
          end else if (op_r == m3mu_pkg::OP_VEC_MAT) begin
            j_nxt = j_r + 2'd1;
          end else if (j_r == 2'd2) begin
            j_nxt = 2'd0;
            i_nxt = i_r + 2'd1;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      default: state_nxt = m3mu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= m3mu_pkg::ST_IDLE;
      op_r        <= m3mu_pkg::OP_MAT_MAT;
      i_r         <= 2'd0;
      j_r         <= 2'd0;
      k_r         <= 2'd0;
      frac_r      <= 5'd16;
      out_valid_r <= 1'b0;
      for (int n = 0; n < 9; n++) begin
        left_r[n]  <= '0;
        right_r[n] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= (state_r == m3mu_pkg::ST_FIN);
      if (cfg_we) begin
        frac_r <= cfg_wdata;
      end
      if (accept && is_load && pos_ok) begin
        if (in_op == m3mu_pkg::OP_LOAD_LEFT) begin
          left_r[m3mu_pkg::elem_idx(in_row, in_col)] <= in_value[DATA_WIDTH-1:0];
        end else begin
          right_r[m3mu_pkg::elem_idx(in_row, in_col)] <= in_value[DATA_WIDTH-1:0];
        end
      end
    end
  end

  // datapath: no reset needed
  always_ff @(posedge clk) begin
    if (state_r == m3mu_pkg::ST_MUL) begin
      prod_r <= a_op * b_op;
    end
    if (state_r == m3mu_pkg::ST_ACC) begin
      acc_r <= ((k_r == 2'd0) ? '0 : acc_r) + ACC_W'(prod_r);
    end
    if (state_r == m3mu_pkg::ST_FIN) begin
      out_value_r <= 32'(res_v);
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_sat_r   <= ~fits;
      out_last_r  <= elem_done;
    end
  end

  assign busy             = (state_r != m3mu_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_saturated    = out_sat_r;
  assign out_last         = out_last_r;

endmodule
